/* hw/rtl/rtpfu_pkg.sv */
// ----------------------------------------------------------------------------
// RTP H.264 FU-A packetizer package
// Shared types and constants for the packetizer core.
// ----------------------------------------------------------------------------
package rtpfu_pkg;

    localparam int MAX_NAL_BYTES = 524288;
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);

    localparam logic [4:0] FU_A_TYPE  = 5'd28;
    localparam logic [7:0] RTP_V2     = 8'h80;
    localparam logic [3:0] HDR_LEN    = 4'd12;
    localparam logic [3:0] FU_IND_POS = 4'd12;
    localparam logic [3:0] FU_HDR_POS = 4'd13;

    localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd0;
    localparam logic [1:0] REG_SOURCE_ID    = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;
    localparam logic [1:0] REG_TS_INCREMENT = 2'd3;

    localparam logic [6:0]  RST_PAYLOAD_TYPE = 7'd96;
    localparam logic [31:0] RST_SOURCE_ID    = 32'd1111;
    localparam logic [10:0] RST_MAX_PAYLOAD  = 11'd1400;
    localparam logic [15:0] RST_TS_INCREMENT = 16'd3600;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        nal_first;
        logic [19:0] nal_length;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_end;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] source_id;
        logic [10:0] max_payload;
        logic [15:0] ts_increment;
    } t_cfg;

    typedef struct packed {
        logic        hdr;
        logic        fu;
        logic        marker;
        logic        pend;
        logic [7:0]  data;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [15:0] seq;
        logic [31:0] ts;
    } t_cmd;

endpackage

/* hw/rtl/rtpfu_front.sv */
// ----------------------------------------------------------------------------
// RTP packetizer front end
// Tracks unit and fragment state per byte and issues packet commands.
// ----------------------------------------------------------------------------
module rtpfu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  rtpfu_pkg::t_in  i_nal,
    input  rtpfu_pkg::t_cfg i_cfg,
    output logic           o_cmd_push,
    output rtpfu_pkg::t_cmd o_cmd
);

    logic [15:0] r_seq, n_seq;
    logic [31:0] r_ts, n_ts;
    logic [19:0] r_left, n_left;
    logic [10:0] r_fill, n_fill;
    logic        r_frag, n_frag;
    logic [7:0]  r_fu_ind, n_fu_ind;
    logic [4:0]  r_type, n_type;
    logic        r_spend, n_spend;

    logic [10:0] w_mp;
    logic [20:0] w_len;
    logic [20:0] w_total;
    logic [19:0] w_left0;
    logic [31:0] w_ts_new;
    logic        w_big;
    logic        w_cut;
    logic [10:0] w_size;
    logic        w_last;
    logic [10:0] w_fill_new;
    logic [19:0] w_left_dec;

    always_comb begin
        w_mp       = (i_cfg.max_payload == 11'd0) ? 11'd1 : i_cfg.max_payload;
        w_len      = (i_nal.nal_length == 20'd0) ? 21'd1 : {1'b0, i_nal.nal_length};
        w_total    = (w_len > 21'(rtpfu_pkg::MAX_NAL_BYTES))
                   ? 21'(rtpfu_pkg::MAX_NAL_BYTES) : w_len;
        w_left0    = 20'(w_total - 21'd1);
        w_ts_new   = r_ts + {16'd0, i_cfg.ts_increment};
        w_big      = r_left > {9'd0, w_mp};
        w_cut      = r_spend && (r_left >= 20'd2);
        w_size     = w_big ? w_mp : (w_cut ? 11'(r_left - 20'd1) : 11'(r_left));
        w_last     = !w_big && !w_cut;
        w_fill_new = ((r_fill == 11'd0) ? w_size : r_fill) - 11'd1;
        w_left_dec = r_left - 20'd1;
    end

    always_comb begin
        n_seq    = r_seq;
        n_ts     = r_ts;
        n_left   = r_left;
        n_fill   = r_fill;
        n_frag   = r_frag;
        n_fu_ind = r_fu_ind;
        n_type   = r_type;
        n_spend  = r_spend;
        o_cmd_push    = 1'b0;
        o_cmd.hdr     = 1'b0;
        o_cmd.fu      = 1'b0;
        o_cmd.marker  = 1'b0;
        o_cmd.pend    = 1'b0;
        o_cmd.data    = i_nal.nal_byte;
        o_cmd.fu_ind  = r_fu_ind;
        o_cmd.fu_hdr  = {r_spend, w_last, 1'b0, r_type};
        o_cmd.seq     = r_seq;
        o_cmd.ts      = r_ts;
        if (i_take) begin
            if (i_nal.nal_first) begin
                n_ts   = w_ts_new;
                n_fill = 11'd0;
                n_left = w_left0;
                if (w_total <= {10'd0, w_mp}) begin
                    n_frag       = 1'b0;
                    n_spend      = 1'b0;
                    o_cmd_push   = 1'b1;
                    o_cmd.hdr    = 1'b1;
                    o_cmd.marker = 1'b1;
                    o_cmd.pend   = (w_left0 == 20'd0);
                    o_cmd.ts     = w_ts_new;
                    n_seq        = r_seq + 16'd1;
                end else begin
                    n_frag   = 1'b1;
                    n_spend  = 1'b1;
                    n_fu_ind = {i_nal.nal_byte[7:5], rtpfu_pkg::FU_A_TYPE};
                    n_type   = i_nal.nal_byte[4:0];
                end
            end else if (r_left != 20'd0) begin
                n_left     = w_left_dec;
                o_cmd_push = 1'b1;
                if (!r_frag) begin
                    o_cmd.pend = (w_left_dec == 20'd0);
                end else begin
                    n_fill     = w_fill_new;
                    o_cmd.pend = (w_fill_new == 11'd0);
                    if (r_fill == 11'd0) begin
                        o_cmd.hdr    = 1'b1;
                        o_cmd.fu     = 1'b1;
                        o_cmd.marker = w_last;
                        n_spend      = 1'b0;
                        n_seq        = r_seq + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= '0;
            r_ts     <= '0;
            r_left   <= '0;
            r_fill   <= '0;
            r_frag   <= 1'b0;
            r_fu_ind <= '0;
            r_type   <= '0;
            r_spend  <= 1'b0;
        end else begin
            r_seq    <= n_seq;
            r_ts     <= n_ts;
            r_left   <= n_left;
            r_fill   <= n_fill;
            r_frag   <= n_frag;
            r_fu_ind <= n_fu_ind;
            r_type   <= n_type;
            r_spend  <= n_spend;
        end
    end

endmodule

/* hw/rtl/rtpfu_cmdq.sv */
// ----------------------------------------------------------------------------
// RTP packetizer command queue
// Small register queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module rtpfu_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  rtpfu_pkg::t_cmd i_cmd,
    input  logic           i_rd,
    output rtpfu_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);

    rtpfu_pkg::t_cmd r_mem [rtpfu_pkg::QDEPTH];
    logic [rtpfu_pkg::QAW-1:0] r_wp, r_rp;
    logic [rtpfu_pkg::QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (rtpfu_pkg::QAW+1)'(rtpfu_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (rtpfu_pkg::QAW+1)'(i_wr) - (rtpfu_pkg::QAW+1)'(i_rd);
        end
    end

endmodule

/* hw/rtl/rtpfu_back.sv */
// ----------------------------------------------------------------------------
// RTP packetizer byte sequencer
// Expands each command into header, FU and payload bytes, one per cycle while the result register is free or popped.
// ----------------------------------------------------------------------------
module rtpfu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  rtpfu_pkg::t_cmd i_cmd,
    input  rtpfu_pkg::t_cfg i_cfg,
    output logic           o_cmd_pop,
    output logic           o_valid,
    output rtpfu_pkg::t_out o_res,
    input  logic           i_pop
);

    logic [3:0]       r_step;
    logic             r_valid;
    rtpfu_pkg::t_out  r_res;
    rtpfu_pkg::t_out  w_res;
    logic [3:0]       w_cnt;
    logic             w_last;
    logic             w_adv;

    always_comb begin
        w_cnt  = i_cmd.hdr ? (i_cmd.fu ? 4'd15 : 4'd13) : 4'd1;
        w_last = (r_step == w_cnt - 4'd1);
        w_res.packet_start = i_cmd.hdr && (r_step == 4'd0);
        w_res.packet_end   = 1'b0;
        w_res.run_last     = w_last;
        w_res.out_byte     = i_cmd.data;
        if (i_cmd.hdr && r_step < rtpfu_pkg::HDR_LEN) begin
            case (r_step)
                4'd0:    w_res.out_byte = rtpfu_pkg::RTP_V2;
                4'd1:    w_res.out_byte = {i_cmd.marker, i_cfg.payload_type};
                4'd2:    w_res.out_byte = i_cmd.seq[15:8];
                4'd3:    w_res.out_byte = i_cmd.seq[7:0];
                4'd4:    w_res.out_byte = i_cmd.ts[31:24];
                4'd5:    w_res.out_byte = i_cmd.ts[23:16];
                4'd6:    w_res.out_byte = i_cmd.ts[15:8];
                4'd7:    w_res.out_byte = i_cmd.ts[7:0];
                4'd8:    w_res.out_byte = i_cfg.source_id[31:24];
                4'd9:    w_res.out_byte = i_cfg.source_id[23:16];
                4'd10:   w_res.out_byte = i_cfg.source_id[15:8];
                default: w_res.out_byte = i_cfg.source_id[7:0];
            endcase
        end else if (i_cmd.fu && r_step == rtpfu_pkg::FU_IND_POS) begin
            w_res.out_byte = i_cmd.fu_ind;
        end else if (i_cmd.fu && r_step == rtpfu_pkg::FU_HDR_POS) begin
            w_res.out_byte = i_cmd.fu_hdr;
        end else begin
            w_res.packet_end = i_cmd.pend;
        end
        w_adv     = i_cmd_valid && (!r_valid || i_pop);
        o_cmd_pop = w_adv && w_last;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_step <= w_last ? 4'd0 : r_step + 4'd1;
            end
            if (w_adv) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/rtp_h264_fua_packetizer_core.sv */
// ----------------------------------------------------------------------------
// RTP H.264 FU-A packetizer core
// NAL bytes in, RTP packet bytes out (single NAL unit and FU-A packets).
//
//   channel   direction  handshake        payload
//   nal       in         push / full      i_nal  (rtpfu_pkg::t_in)
//   result    out        pop / empty      o_res  (rtpfu_pkg::t_out)
//   config    in         i_cfg_we         i_cfg_idx, i_cfg_data
//
// One byte is accepted per cycle while the command queue has room.
// Results leave at one byte per cycle from the sequencer while the consumer
// pops; a packet start emits 12 header bytes (14 with FU bytes), during
// which input keeps filling the four-entry queue and then stalls on full.
// Reset is synchronous; all control state clears.
// ----------------------------------------------------------------------------
module rtp_h264_fua_packetizer_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  rtpfu_pkg::t_in  i_nal,
    output logic            empty,
    input  logic            pop,
    output rtpfu_pkg::t_out o_res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);

    rtpfu_pkg::t_cfg r_cfg;
    rtpfu_pkg::t_cmd w_fcmd;
    rtpfu_pkg::t_cmd w_qcmd;
    logic            w_take;
    logic            w_fpush;
    logic            w_qpop;
    logic            w_qempty;
    logic            w_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_type <= rtpfu_pkg::RST_PAYLOAD_TYPE;
            r_cfg.source_id    <= rtpfu_pkg::RST_SOURCE_ID;
            r_cfg.max_payload  <= rtpfu_pkg::RST_MAX_PAYLOAD;
            r_cfg.ts_increment <= rtpfu_pkg::RST_TS_INCREMENT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtpfu_pkg::REG_PAYLOAD_TYPE: r_cfg.payload_type <= i_cfg_data[6:0];
                rtpfu_pkg::REG_SOURCE_ID:    r_cfg.source_id    <= i_cfg_data;
                rtpfu_pkg::REG_MAX_PAYLOAD:  r_cfg.max_payload  <= i_cfg_data[10:0];
                rtpfu_pkg::REG_TS_INCREMENT: r_cfg.ts_increment <= i_cfg_data[15:0];
                default:                     r_cfg <= r_cfg;
            endcase
        end
    end

    assign w_take = push && !full;
    assign empty  = !w_ovalid;

    rtpfu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_nal      (i_nal),
        .i_cfg      (r_cfg),
        .o_cmd_push (w_fpush),
        .o_cmd      (w_fcmd)
    );

    rtpfu_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fpush),
        .i_cmd   (w_fcmd),
        .i_rd    (w_qpop),
        .o_cmd   (w_qcmd),
        .o_full  (full),
        .o_empty (w_qempty)
    );

    rtpfu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_qempty),
        .i_cmd       (w_qcmd),
        .i_cfg       (r_cfg),
        .o_cmd_pop   (w_qpop),
        .o_valid     (w_ovalid),
        .o_res       (o_res),
        .i_pop       (pop)
    );

    a_start_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.packet_start) |-> (o_res.out_byte == rtpfu_pkg::RTP_V2))
        else $error("packet start without RTP version byte");

    a_start_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_res.packet_start && o_res.packet_end))
        else $error("packet start and end on one byte");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.packet_end) |-> o_res.run_last)
        else $error("packet end not on last byte of its run");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

endmodule
